### design/rdm_pkg.sv
`default_nettype none
package rdm_pkg;

	localparam logic [1:0] OP_PUSH_BACK  = 2'd0;
	localparam logic [1:0] OP_PUSH_FRONT = 2'd1;
	localparam logic [1:0] OP_POP_FRONT  = 2'd2;
	localparam logic [1:0] OP_NOP        = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OK_EMPTY  = 2'd1;
	localparam logic [1:0] ST_REJECTED  = 2'd2;
	localparam logic [1:0] ST_POP_EMPTY = 2'd3;

	// controller -> datapath commands
	typedef struct packed {
		logic cfg_wr;   // capacity register write, empties the queue
		logic capture;  // latch operands, launch slot read at read pointer
		logic exec;     // perform the operation, register the result
	} cmd_t;

endpackage
`default_nettype wire

### design/rdm_ram.sv
`default_nettype none
module rdm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

### design/rdm_ctrl.sv
`default_nettype none
module rdm_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic          cfg_valid,
	output logic               busy,
	output logic               cfg_ready,
	output logic               done,
	output rdm_pkg::cmd_t      cmd
);
	import rdm_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   done_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= (state_q == S_EXEC);
		end
	end

	assign busy        = (state_q != S_IDLE);
	// a start in the same cycle wins; config waits until idle with no start
	assign cfg_ready   = (state_q == S_IDLE) && !start;
	assign cmd.capture = (state_q == S_IDLE) && start;
	assign cmd.exec    = (state_q == S_EXEC);
	assign cmd.cfg_wr  = cfg_valid && cfg_ready;
	assign done        = done_q;
endmodule
`default_nettype wire

### design/rdm_datapath.sv
`default_nettype none
module rdm_datapath #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire rdm_pkg::cmd_t                cmd,
	input  wire logic [$clog2(DEPTH+1)-1:0]   cfg_value,
	input  wire logic [1:0]                   opcode,
	input  wire logic [DATA_WIDTH-1:0]        entry_data,
	input  wire logic [$clog2(DEPTH+1)-1:0]   margin,
	output logic      [1:0]                   status,
	output logic      [DATA_WIDTH-1:0]        data_out,
	output logic      [$clog2(DEPTH+1)-1:0]   busy_count,
	output logic      [$clog2(DEPTH+1)-1:0]   free_low_mark
);
	import rdm_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int PTR_W = $clog2(DEPTH);

	logic [CNT_W-1:0]      cap_q, free_q, fmin_q;
	logic [PTR_W-1:0]      rd_ptr_q, wr_ptr_q;
	logic                  full_q;
	logic [1:0]            op_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic [CNT_W-1:0]      margin_q;

	logic [1:0]            status_q;
	logic [DATA_WIDTH-1:0] dout_q;
	logic [CNT_W-1:0]      busy_cnt_q, low_mark_q;

	logic [DATA_WIDTH-1:0] ram_rdata;
	logic                  ram_we;
	logic [PTR_W-1:0]      ram_waddr;

	logic [CNT_W-1:0]      cap_new;
	logic [CNT_W-1:0]      wr_p1, rd_p1;
	logic [PTR_W-1:0]      wr_inc, rd_inc, rd_dec;
	logic                  is_push, reject, empty_before, is_empty;
	logic [PTR_W-1:0]      rd_nxt, wr_nxt;
	logic                  full_nxt;
	logic [CNT_W-1:0]      free_nxt, fmin_nxt;
	logic [1:0]            status_nxt;
	logic [DATA_WIDTH-1:0] dout_nxt;

	rdm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (data_q),
		.re    (cmd.capture),
		.raddr (rd_ptr_q),
		.rdata (ram_rdata)
	);

	always_comb begin
		if (cfg_value == '0) begin
			cap_new = CNT_W'(1);
		end else if (cfg_value > CNT_W'(DEPTH)) begin
			cap_new = CNT_W'(DEPTH);
		end else begin
			cap_new = cfg_value;
		end
	end

	// pointer wrap at the capacity in use
	assign wr_p1  = CNT_W'(wr_ptr_q) + CNT_W'(1);
	assign rd_p1  = CNT_W'(rd_ptr_q) + CNT_W'(1);
	assign wr_inc = (wr_p1 == cap_q) ? '0 : PTR_W'(wr_p1);
	assign rd_inc = (rd_p1 == cap_q) ? '0 : PTR_W'(rd_p1);
	assign rd_dec = (rd_ptr_q == '0) ? PTR_W'(cap_q - CNT_W'(1)) : rd_ptr_q - PTR_W'(1);

	assign is_push      = (op_q == OP_PUSH_BACK) || (op_q == OP_PUSH_FRONT);
	assign reject       = (margin_q >= cap_q) || (free_q <= margin_q);
	assign empty_before = (free_q == cap_q);
	assign is_empty     = (rd_ptr_q == wr_ptr_q) && !full_q;

	always_comb begin
		rd_nxt     = rd_ptr_q;
		wr_nxt     = wr_ptr_q;
		full_nxt   = full_q;
		free_nxt   = free_q;
		fmin_nxt   = fmin_q;
		status_nxt = ST_OK;
		dout_nxt   = '0;
		ram_we     = 1'b0;
		ram_waddr  = wr_ptr_q;
		case (op_q)
			OP_PUSH_BACK, OP_PUSH_FRONT: begin
				if (reject) begin
					status_nxt = ST_REJECTED;
				end else begin
					ram_we = cmd.exec;
					if (op_q == OP_PUSH_FRONT) begin
						rd_nxt    = rd_dec;
						ram_waddr = rd_dec;
					end else begin
						wr_nxt = wr_inc;
					end
					full_nxt   = (wr_nxt == rd_nxt);
					free_nxt   = free_q - CNT_W'(1);
					fmin_nxt   = (free_nxt < fmin_q) ? free_nxt : fmin_q;
					status_nxt = empty_before ? ST_OK_EMPTY : ST_OK;
				end
			end
			OP_POP_FRONT: begin
				if (is_empty) begin
					status_nxt = ST_POP_EMPTY;
				end else begin
					dout_nxt = ram_rdata;
					rd_nxt   = rd_inc;
					full_nxt = 1'b0;
					free_nxt = free_q + CNT_W'(1);
				end
			end
			default: begin
				status_nxt = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= CNT_W'(DEPTH);
			free_q   <= CNT_W'(DEPTH);
			fmin_q   <= CNT_W'(DEPTH);
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			full_q   <= 1'b0;
		end else if (cmd.cfg_wr) begin
			cap_q    <= cap_new;
			free_q   <= cap_new;
			fmin_q   <= cap_new;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			full_q   <= 1'b0;
		end else if (cmd.exec) begin
			free_q   <= free_nxt;
			fmin_q   <= fmin_nxt;
			rd_ptr_q <= rd_nxt;
			wr_ptr_q <= wr_nxt;
			full_q   <= full_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= opcode;
			data_q   <= entry_data;
			margin_q <= margin;
		end
		if (cmd.exec) begin
			status_q   <= status_nxt;
			dout_q     <= dout_nxt;
			busy_cnt_q <= cap_q - free_nxt;
			low_mark_q <= fmin_nxt;
		end
	end

	assign status        = status_q;
	assign data_out      = dout_q;
	assign busy_count    = busy_cnt_q;
	assign free_low_mark = low_mark_q;

	a_free_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= cap_q) else $error("free count above capacity");

	a_min_le_free: assert property (@(posedge clk) disable iff (!arst_n)
		fmin_q <= free_q) else $error("low-water mark above free count");

	a_full_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |-> (rd_ptr_q == wr_ptr_q) && (free_q == '0))
		else $error("full flag without zero free count");

	a_empty_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		((rd_ptr_q == wr_ptr_q) && !full_q) |-> (free_q == cap_q))
		else $error("empty pointers but entries counted");
endmodule
`default_nettype wire

### design/ring_deque_with_margin.sv
// Channel   Handshake                 Payload
// ------    ---------                 -------
// input     start & !busy             opcode, entry_data, margin
// result    done (one-cycle strobe)   status, data_out, busy_count, free_low_mark
// config    cfg_valid & cfg_ready     capacity_in_use
//
// An operation has a capture step, which launches the slot RAM read at the read
// pointer, and an exec step, which updates pointers/counters and writes the RAM. done
// rises the cycle after exec, when busy has already dropped, so a new start is taken then.
// Result ports cannot be stalled; a result is valid only while done is high.
// Reset clears pointers and sets capacity and counts to DEPTH; slot contents
// are left as is.
`default_nettype none
module ring_deque_with_margin #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [1:0]                   opcode,
	input  wire logic [DATA_WIDTH-1:0]        entry_data,
	input  wire logic [$clog2(DEPTH+1)-1:0]   margin,
	output logic                              done,
	output logic      [1:0]                   status,
	output logic      [DATA_WIDTH-1:0]        data_out,
	output logic      [$clog2(DEPTH+1)-1:0]   busy_count,
	output logic      [$clog2(DEPTH+1)-1:0]   free_low_mark,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [$clog2(DEPTH+1)-1:0]   capacity_in_use
);
	import rdm_pkg::*;

	cmd_t cmd;

	rdm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cfg_valid (cfg_valid),
		.busy      (busy),
		.cfg_ready (cfg_ready),
		.done      (done),
		.cmd       (cmd)
	);

	rdm_datapath #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_value     (capacity_in_use),
		.opcode        (opcode),
		.entry_data    (entry_data),
		.margin        (margin),
		.status        (status),
		.data_out      (data_out),
		.busy_count    (busy_count),
		.free_low_mark (free_low_mark)
	);
endmodule
`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import rdm_pkg::*;

	typedef enum logic [1:0] {ITEM_OP, ITEM_CFG, ITEM_DRAIN} item_kind_t;

	typedef struct {
		item_kind_t  kind;
		logic [1:0]  opcode;
		logic [31:0] data;
		logic [4:0]  margin;
		logic [4:0]  capacity;
	} deque_item_t;

	typedef struct {
		logic [1:0]  status;
		logic [31:0] data;
		logic [4:0]  busy;
		logic [4:0]  low_mark;
	} deque_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  opcode = OP_NOP;
	logic [31:0] entry_data = '0;
	logic [4:0]  margin = '0;
	logic        cfg_valid = 1'b0;
	logic [4:0]  capacity_in_use = 5'd16;
	logic        busy;
	logic        done;
	logic [1:0]  status;
	logic [31:0] data_out;
	logic [4:0]  busy_count;
	logic [4:0]  free_low_mark;
	logic        cfg_ready;

	ring_deque_with_margin #(.DEPTH(16), .DATA_WIDTH(32)) u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.opcode         (opcode),
		.entry_data     (entry_data),
		.margin         (margin),
		.done           (done),
		.status         (status),
		.data_out       (data_out),
		.busy_count     (busy_count),
		.free_low_mark  (free_low_mark),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.capacity_in_use(capacity_in_use)
	);

	deque_item_t   op_queue[$];
	deque_result_t pending_results[$];
	int            mismatch_count = 0;

	// shadow of the deque state
	logic [31:0] shadow_slots [16];
	int          shadow_rd = 0;
	int          shadow_wr = 0;
	bit          shadow_full = 0;
	int          shadow_free = 16;
	int          shadow_min = 16;
	int          shadow_cap = 16;

	initial forever #1 clk = ~clk;

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
	end

	initial begin
		#1_000_000;
		$display("FAIL ring_deque_with_margin");
		$finish;
	end

	task automatic set_capacity(input logic [4:0] value);
		int v;
		v = value;
		if (v < 1) v = 1;
		if (v > 16) v = 16;
		shadow_cap = v;
		shadow_rd = 0;
		shadow_wr = 0;
		shadow_full = 0;
		shadow_free = v;
		shadow_min = v;
	endtask

	task automatic predict_deque_op(input logic [1:0] op, input logic [31:0] d,
			input logic [4:0] m, output deque_result_t r);
		int  mi;
		bit  empty_before;
		mi = m;
		r.status = ST_OK;
		r.data = '0;
		case (op)
			OP_PUSH_BACK, OP_PUSH_FRONT: begin
				if (mi >= shadow_cap || shadow_free <= mi) begin
					r.status = ST_REJECTED;
				end else begin
					empty_before = (shadow_free == shadow_cap);
					if (op == OP_PUSH_FRONT) begin
						shadow_rd = (shadow_rd == 0) ? shadow_cap - 1 : shadow_rd - 1;
						shadow_slots[shadow_rd] = d;
					end else begin
						shadow_slots[shadow_wr] = d;
						shadow_wr = (shadow_wr + 1) % shadow_cap;
					end
					if (shadow_wr == shadow_rd) shadow_full = 1;
					shadow_free--;
					if (shadow_free < shadow_min) shadow_min = shadow_free;
					r.status = empty_before ? ST_OK_EMPTY : ST_OK;
				end
			end
			OP_POP_FRONT: begin
				if (shadow_rd == shadow_wr && !shadow_full) begin
					r.status = ST_POP_EMPTY;
				end else begin
					r.data = shadow_slots[shadow_rd];
					shadow_rd = (shadow_rd + 1) % shadow_cap;
					shadow_full = 0;
					shadow_free++;
				end
			end
			default: ;
		endcase
		r.busy = 5'(shadow_cap - shadow_free);
		r.low_mark = 5'(shadow_min);
	endtask

	// driver
	int burst_left = 8;
	int gap_left = 0;
	int quiet_cycles = 0;

	always @(posedge clk or negedge arst_n) begin
		logic          nxt_start;
		logic          nxt_cfg;
		deque_result_t res;
		deque_item_t   it;
		if (!arst_n) begin
			start <= 1'b0;
			cfg_valid <= 1'b0;
			quiet_cycles <= 0;
		end else begin
			nxt_start = start;
			nxt_cfg = cfg_valid;
			if (start && !busy) begin
				predict_deque_op(opcode, entry_data, margin, res);
				pending_results.push_back(res);
				nxt_start = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				set_capacity(capacity_in_use);
				nxt_cfg = 1'b0;
			end
			if (!nxt_start && !nxt_cfg) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (op_queue.size() > 0) begin
					it = op_queue[0];
					case (it.kind)
						ITEM_OP: begin
							void'(op_queue.pop_front());
							opcode <= it.opcode;
							entry_data <= it.data;
							margin <= it.margin;
							nxt_start = 1'b1;
							burst_left--;
							if (burst_left <= 0) begin
								burst_left = ($urandom_range(0, 7) == 0) ?
									$urandom_range(40, 80) : $urandom_range(1, 16);
								gap_left = ($urandom_range(0, 3) == 0) ? 0 :
									$urandom_range(1, 6);
							end
						end
						ITEM_CFG: begin
							if (quiet_cycles >= 4) begin
								void'(op_queue.pop_front());
								capacity_in_use <= it.capacity;
								nxt_cfg = 1'b1;
							end
						end
						default: begin
							if (quiet_cycles >= 4) void'(op_queue.pop_front());
						end
					endcase
				end
			end
			start <= nxt_start;
			cfg_valid <= nxt_cfg;
			if (pending_results.size() == 0 && !start && !cfg_valid && !done)
				quiet_cycles <= quiet_cycles + 1;
			else
				quiet_cycles <= 0;
		end
	end

	// monitor
	always @(posedge clk) begin
		deque_result_t exp_res;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result status=%0d data=%h busy=%0d low=%0d",
					$realtime, status, data_out, busy_count, free_low_mark);
				mismatch_count++;
			end else begin
				exp_res = pending_results.pop_front();
				if (status !== exp_res.status) begin
					$display("%0t: status expected %0d actual %0d",
						$realtime, exp_res.status, status);
					mismatch_count++;
				end
				if (data_out !== exp_res.data) begin
					$display("%0t: data_out expected %h actual %h",
						$realtime, exp_res.data, data_out);
					mismatch_count++;
				end
				if (busy_count !== exp_res.busy) begin
					$display("%0t: busy_count expected %0d actual %0d",
						$realtime, exp_res.busy, busy_count);
					mismatch_count++;
				end
				if (free_low_mark !== exp_res.low_mark) begin
					$display("%0t: free_low_mark expected %0d actual %0d",
						$realtime, exp_res.low_mark, free_low_mark);
					mismatch_count++;
				end
			end
		end
	end

	task automatic queue_op(input logic [1:0] op, input logic [31:0] d, input logic [4:0] m);
		deque_item_t it;
		it.kind = ITEM_OP;
		it.opcode = op;
		it.data = d;
		it.margin = m;
		it.capacity = '0;
		op_queue.push_back(it);
	endtask

	task automatic queue_cfg(input logic [4:0] value);
		deque_item_t it;
		it.kind = ITEM_CFG;
		it.opcode = OP_NOP;
		it.data = '0;
		it.margin = '0;
		it.capacity = value;
		op_queue.push_back(it);
	endtask

	task automatic queue_drain();
		deque_item_t it;
		it.kind = ITEM_DRAIN;
		it.opcode = OP_NOP;
		it.data = '0;
		it.margin = '0;
		it.capacity = '0;
		op_queue.push_back(it);
	endtask

	initial begin
		int          rand_items;
		int          phase_len;
		int          push_pct;
		int          drain_at;
		int          sel;
		logic [1:0]  op;
		logic [31:0] d;
		logic [4:0]  m;
		logic [4:0]  cap;

		// directed: empty pop, no-op, margin rejects, wrap at tiny capacity, full
		queue_op(OP_POP_FRONT, 32'h1234_5678, 5'd0);
		queue_op(OP_NOP, 32'hFFFF_FFFF, 5'd31);
		queue_op(OP_PUSH_BACK, 32'h0000_0000, 5'd0);
		queue_op(OP_PUSH_FRONT, 32'hFFFF_FFFF, 5'd0);
		queue_op(OP_PUSH_BACK, 32'hDEAD_BEEF, 5'd16);
		queue_op(OP_PUSH_FRONT, 32'hDEAD_BEEF, 5'd31);
		queue_op(OP_PUSH_BACK, 32'h0BAD_F00D, 5'd14);
		queue_op(OP_PUSH_BACK, 32'hA5A5_5A5A, 5'd13);
		queue_op(OP_POP_FRONT, 32'h0, 5'd0);
		queue_op(OP_POP_FRONT, 32'h0, 5'd0);
		queue_op(OP_POP_FRONT, 32'h0, 5'd0);
		queue_op(OP_POP_FRONT, 32'h0, 5'd0);
		queue_cfg(5'd1);
		queue_op(OP_PUSH_FRONT, 32'h5A5A_A5A5, 5'd0);
		queue_op(OP_PUSH_BACK, 32'h1111_1111, 5'd0);
		queue_op(OP_POP_FRONT, 32'h0, 5'd0);
		queue_op(OP_PUSH_BACK, 32'h2222_2222, 5'd0);
		queue_op(OP_POP_FRONT, 32'h0, 5'd0);
		queue_cfg(5'd0);
		queue_op(OP_PUSH_BACK, 32'h3333_3333, 5'd0);
		queue_cfg(5'd31);
		queue_op(OP_PUSH_FRONT, 32'h4444_4444, 5'd0);
		queue_op(OP_PUSH_FRONT, 32'h5555_5555, 5'd1);
		queue_cfg(5'd3);
		queue_op(OP_PUSH_BACK, 32'h6666_6666, 5'd0);
		queue_op(OP_PUSH_BACK, 32'h7777_7777, 5'd0);
		queue_op(OP_PUSH_FRONT, 32'h8888_8888, 5'd0);
		queue_op(OP_PUSH_BACK, 32'h9999_9999, 5'd0);
		queue_drain();
		queue_op(OP_POP_FRONT, 32'h0, 5'd0);
		queue_op(OP_POP_FRONT, 32'h0, 5'd0);

		// random phases, each with its own capacity and push/pop bias
		rand_items = 0;
		while (rand_items < 1100) begin
			sel = $urandom_range(0, 99);
			if (sel < 20) cap = 5'd1;
			else if (sel < 40) cap = 5'd16;
			else if (sel < 45) cap = 5'd0;
			else if (sel < 50) cap = 5'($urandom_range(17, 31));
			else cap = 5'($urandom_range(2, 15));
			queue_cfg(cap);
			case ($urandom_range(0, 2))
				0: push_pct = 30;
				1: push_pct = 50;
				default: push_pct = 70;
			endcase
			phase_len = $urandom_range(30, 70);
			drain_at = ($urandom_range(0, 1) == 0) ? $urandom_range(1, phase_len - 1) : -1;
			for (int i = 0; i < phase_len; i++) begin
				if (i == drain_at) queue_drain();
				sel = $urandom_range(0, 99);
				if (sel < 3) op = OP_NOP;
				else if (sel < 3 + push_pct)
					op = ($urandom_range(0, 1) == 0) ? OP_PUSH_BACK : OP_PUSH_FRONT;
				else op = OP_POP_FRONT;
				sel = $urandom_range(0, 19);
				if (sel == 0) d = 32'h0;
				else if (sel == 1) d = 32'hFFFF_FFFF;
				else d = $urandom;
				m = ($urandom_range(0, 4) != 0) ? 5'($urandom_range(0, 2)) :
					5'($urandom_range(0, 31));
				queue_op(op, d, m);
			end
			rand_items += phase_len;
		end

		@(posedge arst_n);
		while (op_queue.size() != 0 || start || cfg_valid || pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("PASS ring_deque_with_margin");
		else
			$display("FAIL ring_deque_with_margin");
		$finish;
	end

endmodule
